// ===== src/dam_pkg.sv =====
// Shared types, widths, codes and helpers of the decimal accumulator machine.
package dam_pkg;

   // Field widths fixed by the item formats.
   localparam int DATA_W   = 17;
   localparam int WORD_W   = 15;
   localparam int CNT_W    = 7;
   localparam int FIELD_W  = 8;
   localparam int STATUS_W = 4;
   localparam int MAG_W    = 14;
   localparam int WIDE_W   = 30;

   // Legal word range.
   localparam int WORD_MIN = -9999;
   localparam int WORD_MAX = 9999;

   // Division by one hundred through a reciprocal: q = (x * 5243) >> 19 for x <= 9999.
   localparam int DEC_BASE      = 100;
   localparam int DIV100_MUL    = 5243;
   localparam int DIV100_SHIFT  = 19;
   localparam int QP_W          = MAG_W + 13;
   localparam int QDIGIT_W      = 7;

   // Instruction opcodes.
   localparam logic signed [FIELD_W-1:0] OPC_READ   = 8'sd10;
   localparam logic signed [FIELD_W-1:0] OPC_WRITE  = 8'sd11;
   localparam logic signed [FIELD_W-1:0] OPC_LOAD   = 8'sd20;
   localparam logic signed [FIELD_W-1:0] OPC_STORE  = 8'sd21;
   localparam logic signed [FIELD_W-1:0] OPC_ADD    = 8'sd30;
   localparam logic signed [FIELD_W-1:0] OPC_SUB    = 8'sd31;
   localparam logic signed [FIELD_W-1:0] OPC_DIV    = 8'sd32;
   localparam logic signed [FIELD_W-1:0] OPC_MUL    = 8'sd33;
   localparam logic signed [FIELD_W-1:0] OPC_BRANCH = 8'sd40;
   localparam logic signed [FIELD_W-1:0] OPC_BRNEG  = 8'sd41;
   localparam logic signed [FIELD_W-1:0] OPC_BRZERO = 8'sd42;
   localparam logic signed [FIELD_W-1:0] OPC_HALT   = 8'sd43;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_LOADED           = 4'd0,
      ST_LOAD_REJECTED    = 4'd1,
      ST_MEMORY_FULL      = 4'd2,
      ST_EXECUTED         = 4'd3,
      ST_HALTED           = 4'd4,
      ST_READ_REJECTED    = 4'd5,
      ST_OVERFLOW         = 4'd6,
      ST_DIVIDE_ZERO      = 4'd7,
      ST_BAD_OPCODE       = 4'd8,
      ST_COUNTER_OVERFLOW = 4'd9,
      ST_STOPPED          = 4'd10
   } status_type;

   // Divider result returned to the sequencer.
   typedef struct packed {
      logic                     done;
      logic signed [WORD_W-1:0] quotient;
   } div_res_type;

   // True when a value lies in the legal word range.
   function automatic logic word_ok(input logic signed [WIDE_W-1:0] v);
      return (v >= WIDE_W'(WORD_MIN)) && (v <= WIDE_W'(WORD_MAX));
   endfunction

endpackage

// ===== src/dam_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module dam_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dam_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module dam_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [dam_pkg::WORD_W-1:0] dividend,
   input  logic signed [dam_pkg::WORD_W-1:0] divisor,
   output dam_pkg::div_res_type              res
);
   import dam_pkg::*;

   localparam int CW = $clog2(MAG_W);

   logic              run_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [CW-1:0]     cnt_ff;
   logic [MAG_W:0]    rem_ff;
   logic [MAG_W-1:0]  quo_ff;
   logic [MAG_W-1:0]  dmag_ff;
   logic [WORD_W-1:0] a_abs;
   logic [WORD_W-1:0] b_abs;
   logic [MAG_W:0]    rem_sh;
   logic [MAG_W+1:0]  diff;
   logic [WORD_W-1:0] quo_ext;

   // Operand magnitudes and one restoring step.
   always_comb begin
      a_abs  = dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
      b_abs  = divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
      rem_sh = {rem_ff[MAG_W-1:0], quo_ff[MAG_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dmag_ff};
   end

   // Iteration control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= a_abs[MAG_W-1:0];
            dmag_ff <= b_abs[MAG_W-1:0];
            neg_ff  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
         end else if (run_ff) begin
            if (!diff[MAG_W+1]) begin
               rem_ff <= diff[MAG_W:0];
               quo_ff <= {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[MAG_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAG_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Apply the quotient sign.
   assign quo_ext      = {1'b0, quo_ff};
   assign res.done     = done_ff;
   assign res.quotient = neg_ff ? WORD_W'(-quo_ext) : quo_ext;

endmodule

// ===== src/decimal_accumulator_machine.sv =====
// Top level of the decimal accumulator machine: sequencer around the program memory.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  request   | start in, busy out         | req_op, req_data_word
//  response  | rsp_strobe out, one cycle  | rsp_status .. rsp_write_value
//
// A load item is written and answered from S_LOAD; a step runs through S_FETCH, S_SPLIT,
// S_DECODE, S_OPREAD and S_EXEC (a stopped machine answers from S_FETCH), multiply adds
// S_MULCHK and divide waits in S_DIVWAIT, because each instruction issues two reads to the
// one read port of the program memory (fetch, then operand) and the divider produces one
// quotient bit per cycle. busy is high from acceptance until the response is registered;
// the strobe cycle can already accept the next item.
// Synchronous reset clears the machine state and the per-word valid bits; words never
// written read as zero. The receiver cannot stall responses.
module decimal_accumulator_machine #(
   parameter int MEM_WORDS = 100
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic signed [dam_pkg::DATA_W-1:0]  req_data_word,
   output logic                               rsp_strobe,
   output logic [dam_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [dam_pkg::WORD_W-1:0]  rsp_accumulator_value,
   output logic [dam_pkg::CNT_W-1:0]          rsp_counter_value,
   output logic signed [dam_pkg::WORD_W-1:0]  rsp_instruction_word,
   output logic signed [dam_pkg::FIELD_W-1:0] rsp_opcode_field,
   output logic signed [dam_pkg::FIELD_W-1:0] rsp_operand_field,
   output logic                               rsp_write_valid,
   output logic [dam_pkg::CNT_W-1:0]          rsp_write_address,
   output logic signed [dam_pkg::WORD_W-1:0]  rsp_write_value
);
   import dam_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_FETCH,
      S_SPLIT,
      S_DECODE,
      S_OPREAD,
      S_EXEC,
      S_MULCHK,
      S_DIVWAIT
   } state_type;

   state_type                  state_ff;
   logic signed [DATA_W-1:0]   data_ff;
   logic signed [WORD_W-1:0]   acc_ff;
   logic [CNT_W-1:0]           pc_ff;
   logic [CNT_W-1:0]           lp_ff;
   logic                       stopped_ff;
   logic [MEM_WORDS-1:0]       valid_ff;
   logic                       rd_ok_ff;
   logic signed [WORD_W-1:0]   ir_ff;
   logic                       neg_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [QP_W-1:0]            qprod_ff;
   logic signed [FIELD_W-1:0]  opc_ff;
   logic signed [FIELD_W-1:0]  opd_ff;
   logic signed [WIDE_W-1:0]   prod_ff;

   logic                       rsp_strobe_ff;
   status_type                 rsp_status_ff;
   logic signed [WORD_W-1:0]   rsp_acc_ff;
   logic [CNT_W-1:0]           rsp_cnt_ff;
   logic signed [WORD_W-1:0]   rsp_ir_ff;
   logic signed [FIELD_W-1:0]  rsp_opc_ff;
   logic signed [FIELD_W-1:0]  rsp_opd_ff;
   logic                       rsp_wv_ff;
   logic [CNT_W-1:0]           rsp_waddr_ff;
   logic signed [WORD_W-1:0]   rsp_wval_ff;

   logic                       ram_we;
   logic [AW-1:0]              ram_wa;
   logic [WORD_W-1:0]          ram_wd;
   logic [AW-1:0]              ram_ra;
   logic [WORD_W-1:0]          ram_rd;
   logic                       rd_range;
   logic signed [WORD_W-1:0]   rd_word;
   logic                       opd_in_range;

   logic [WORD_W-1:0]          abs_c;
   logic [MAG_W-1:0]           mag_c;
   logic [QP_W-1:0]            qprod_c;
   logic [QDIGIT_W-1:0]        q_c;
   logic [MAG_W-1:0]           r_full;
   logic [FIELD_W-1:0]         q8;
   logic [FIELD_W-1:0]         r8;
   logic signed [FIELD_W-1:0]  opc_c;
   logic signed [FIELD_W-1:0]  opd_c;

   logic signed [WORD_W:0]     add_c;
   logic signed [WORD_W:0]     sub_c;
   logic signed [WIDE_W-1:0]   mul_c;
   logic                       load_ok;
   logic                       mul_go;
   logic                       div_go;
   div_res_type                div_res;

   logic                       fin;
   status_type                 st_c;
   logic                       adv_c;
   logic [CNT_W-1:0]           nxt_c;
   logic signed [WORD_W-1:0]   acc_c;
   logic                       stop_c;
   logic                       wv_c;
   logic signed [WORD_W-1:0]   wval_c;

   // Program memory.
   dam_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Divider used only by the divide instruction.
   dam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (acc_ff),
      .divisor  (rd_word),
      .res      (div_res)
   );

   // Memory read address: the counter during fetch, the operand before execute.
   assign opd_in_range = !opd_ff[FIELD_W-1] && (opd_ff[CNT_W-1:0] < CNT_W'(MEM_WORDS));

   always_comb begin
      ram_ra   = '0;
      rd_range = 1'b0;
      case (state_ff)
         S_FETCH: begin
            ram_ra   = pc_ff[AW-1:0];
            rd_range = pc_ff < CNT_W'(MEM_WORDS);
         end
         S_OPREAD: begin
            ram_ra   = opd_ff[AW-1:0];
            rd_range = opd_in_range;
         end
         default: begin
            ram_ra   = '0;
            rd_range = 1'b0;
         end
      endcase
   end

   // Words outside the program or never written read as zero.
   assign rd_word = rd_ok_ff ? $signed(ram_rd) : '0;

   // Decimal split: magnitude times the reciprocal of one hundred, then the remainder.
   always_comb begin
      abs_c   = rd_word[WORD_W-1] ? WORD_W'(-rd_word) : WORD_W'(rd_word);
      mag_c   = abs_c[MAG_W-1:0];
      qprod_c = QP_W'(mag_c) * QP_W'(DIV100_MUL);
      q_c     = qprod_ff[DIV100_SHIFT +: QDIGIT_W];
      r_full  = mag_ff - (MAG_W'(q_c) * MAG_W'(DEC_BASE));
      q8      = {1'b0, q_c};
      r8      = {1'b0, r_full[QDIGIT_W-1:0]};
      opc_c   = neg_ff ? FIELD_W'(-q8) : q8;
      opd_c   = neg_ff ? FIELD_W'(-r8) : r8;
   end

   // Arithmetic on the accumulator and the operand word.
   always_comb begin
      add_c   = (WORD_W+1)'(acc_ff) + (WORD_W+1)'(rd_word);
      sub_c   = (WORD_W+1)'(acc_ff) - (WORD_W+1)'(rd_word);
      mul_c   = acc_ff * rd_word;
      load_ok = word_ok(WIDE_W'(data_ff));
   end

   // Instruction execution, memory writes and the end-of-item decision.
   always_comb begin
      fin    = 1'b0;
      st_c   = ST_EXECUTED;
      adv_c  = 1'b1;
      nxt_c  = pc_ff + 1'b1;
      acc_c  = acc_ff;
      stop_c = 1'b0;
      wv_c   = 1'b0;
      wval_c = '0;
      ram_we = 1'b0;
      ram_wa = opd_ff[AW-1:0];
      ram_wd = '0;
      mul_go = 1'b0;
      div_go = 1'b0;
      case (state_ff)
         S_LOAD: begin
            ram_we = load_ok && (lp_ff < CNT_W'(MEM_WORDS));
            ram_wa = lp_ff[AW-1:0];
            ram_wd = data_ff[WORD_W-1:0];
         end
         S_EXEC: begin
            fin = 1'b1;
            case (opc_ff)
               OPC_READ: begin
                  if (load_ok) begin
                     ram_we = opd_in_range;
                     ram_wd = data_ff[WORD_W-1:0];
                  end else begin
                     st_c  = ST_READ_REJECTED;
                     adv_c = 1'b0;
                  end
               end
               OPC_WRITE: begin
                  wv_c   = 1'b1;
                  wval_c = rd_word;
               end
               OPC_LOAD: begin
                  acc_c = rd_word;
               end
               OPC_STORE: begin
                  ram_we = opd_in_range;
                  ram_wd = acc_ff;
               end
               OPC_ADD: begin
                  if (word_ok(WIDE_W'(add_c))) begin
                     acc_c = add_c[WORD_W-1:0];
                  end else begin
                     st_c   = ST_OVERFLOW;
                     adv_c  = 1'b0;
                     stop_c = 1'b1;
                  end
               end
               OPC_SUB: begin
                  if (word_ok(WIDE_W'(sub_c))) begin
                     acc_c = sub_c[WORD_W-1:0];
                  end else begin
                     st_c   = ST_OVERFLOW;
                     adv_c  = 1'b0;
                     stop_c = 1'b1;
                  end
               end
               OPC_MUL: begin
                  fin    = 1'b0;
                  mul_go = 1'b1;
               end
               OPC_DIV: begin
                  if (rd_word == '0) begin
                     st_c   = ST_DIVIDE_ZERO;
                     adv_c  = 1'b0;
                     stop_c = 1'b1;
                  end else begin
                     fin    = 1'b0;
                     div_go = 1'b1;
                  end
               end
               OPC_BRANCH: begin
                  nxt_c = opd_ff[CNT_W-1:0];
               end
               OPC_BRNEG: begin
                  if (acc_ff[WORD_W-1]) begin
                     nxt_c = opd_ff[CNT_W-1:0];
                  end
               end
               OPC_BRZERO: begin
                  if (acc_ff == '0) begin
                     nxt_c = opd_ff[CNT_W-1:0];
                  end
               end
               OPC_HALT: begin
                  st_c   = ST_HALTED;
                  adv_c  = 1'b0;
                  stop_c = 1'b1;
               end
               default: begin
                  st_c   = ST_BAD_OPCODE;
                  adv_c  = 1'b0;
                  stop_c = 1'b1;
               end
            endcase
         end
         S_MULCHK: begin
            fin = 1'b1;
            if (word_ok(prod_ff)) begin
               acc_c = prod_ff[WORD_W-1:0];
            end else begin
               st_c   = ST_OVERFLOW;
               adv_c  = 1'b0;
               stop_c = 1'b1;
            end
         end
         S_DIVWAIT: begin
            fin   = div_res.done;
            acc_c = div_res.quotient;
         end
         default: begin
            fin = 1'b0;
         end
      endcase
      // A counter that leaves the program stops the machine.
      if (fin && adv_c && (nxt_c >= CNT_W'(MEM_WORDS))) begin
         st_c   = ST_COUNTER_OVERFLOW;
         stop_c = 1'b1;
      end
   end

   // Sequencer, machine state and registered responses.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         acc_ff        <= '0;
         pc_ff         <= '0;
         lp_ff         <= '0;
         stopped_ff    <= 1'b0;
         valid_ff      <= '0;
         rd_ok_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_ok_ff      <= rd_range && valid_ff[ram_ra];
         if (ram_we) begin
            valid_ff[ram_wa] <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  data_ff  <= req_data_word;
                  state_ff <= req_op ? S_FETCH : S_LOAD;
               end
            end
            S_LOAD: begin
               if (!load_ok) begin
                  rsp_status_ff <= ST_LOAD_REJECTED;
               end else if (lp_ff >= CNT_W'(MEM_WORDS)) begin
                  rsp_status_ff <= ST_MEMORY_FULL;
               end else begin
                  rsp_status_ff <= ST_LOADED;
                  lp_ff         <= lp_ff + 1'b1;
               end
               rsp_strobe_ff <= 1'b1;
               rsp_acc_ff    <= acc_ff;
               rsp_cnt_ff    <= pc_ff;
               rsp_ir_ff     <= '0;
               rsp_opc_ff    <= '0;
               rsp_opd_ff    <= '0;
               rsp_wv_ff     <= 1'b0;
               rsp_waddr_ff  <= '0;
               rsp_wval_ff   <= '0;
               state_ff      <= S_IDLE;
            end
            S_FETCH: begin
               if (stopped_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= ST_STOPPED;
                  rsp_acc_ff    <= acc_ff;
                  rsp_cnt_ff    <= pc_ff;
                  rsp_ir_ff     <= '0;
                  rsp_opc_ff    <= '0;
                  rsp_opd_ff    <= '0;
                  rsp_wv_ff     <= 1'b0;
                  rsp_waddr_ff  <= '0;
                  rsp_wval_ff   <= '0;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_SPLIT;
               end
            end
            S_SPLIT: begin
               ir_ff    <= rd_word;
               neg_ff   <= rd_word[WORD_W-1];
               mag_ff   <= mag_c;
               qprod_ff <= qprod_c;
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               opc_ff   <= opc_c;
               opd_ff   <= opd_c;
               state_ff <= S_OPREAD;
            end
            S_OPREAD: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (mul_go) begin
                  prod_ff  <= mul_c;
                  state_ff <= S_MULCHK;
               end else if (div_go) begin
                  state_ff <= S_DIVWAIT;
               end
            end
            S_MULCHK: begin
               state_ff <= S_IDLE;
            end
            S_DIVWAIT: begin
               if (div_res.done) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         // Commit an executed instruction.
         if (fin) begin
            acc_ff <= acc_c;
            if (adv_c) begin
               pc_ff <= nxt_c;
            end
            if (stop_c) begin
               stopped_ff <= 1'b1;
            end
            rsp_strobe_ff <= 1'b1;
            rsp_status_ff <= st_c;
            rsp_acc_ff    <= acc_c;
            rsp_cnt_ff    <= adv_c ? nxt_c : pc_ff;
            rsp_ir_ff     <= ir_ff;
            rsp_opc_ff    <= opc_ff;
            rsp_opd_ff    <= opd_ff;
            rsp_wv_ff     <= wv_c;
            rsp_waddr_ff  <= wv_c ? opd_ff[CNT_W-1:0] : '0;
            rsp_wval_ff   <= wval_c;
            state_ff      <= S_IDLE;
         end
      end
   end

   // Ports.
   assign busy                  = (state_ff != S_IDLE);
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_accumulator_value = rsp_acc_ff;
   assign rsp_counter_value     = rsp_cnt_ff;
   assign rsp_instruction_word  = rsp_ir_ff;
   assign rsp_opcode_field      = rsp_opc_ff;
   assign rsp_operand_field     = rsp_opd_ff;
   assign rsp_write_valid       = rsp_wv_ff;
   assign rsp_write_address     = rsp_waddr_ff;
   assign rsp_write_value       = rsp_wval_ff;

endmodule

// ===== src/dam_checker.sv =====
// Port-level checks of the decimal accumulator machine and their binding.
module dam_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic [dam_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [dam_pkg::WORD_W-1:0]  rsp_instruction_word,
   input logic                               rsp_write_valid
);
   import dam_pkg::*;

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Each item gives one response; two strobes never follow each other.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // A shown memory word comes only from a completed write instruction.
   a_write_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_write_valid) |->
         (rsp_status == ST_EXECUTED || rsp_status == ST_COUNTER_OVERFLOW))
      else $error("write word shown with wrong status");

   // Loads and stopped steps fetch nothing.
   a_no_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_LOADED || rsp_status == ST_LOAD_REJECTED ||
                      rsp_status == ST_MEMORY_FULL || rsp_status == ST_STOPPED)) |->
         (rsp_instruction_word == '0 && !rsp_write_valid))
      else $error("instruction fields set on a response without fetch");

endmodule

bind decimal_accumulator_machine dam_checker u_dam_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_strobe           (rsp_strobe),
   .rsp_status           (rsp_status),
   .rsp_instruction_word (rsp_instruction_word),
   .rsp_write_valid      (rsp_write_valid)
);
